@@ rtl/core/segtree_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: shared package
// Field widths, default sizing, request mode codes and controller states.
// ----------------------------------------------------------------------------
package segtree_pkg;

   localparam int SUM_W                = 42;
   localparam int INDEX_W              = 10;
   localparam int VALUE_W              = 32;
   localparam int COUNT_W              = 11;
   localparam int DEFAULT_MAX_ELEMENTS = 1024;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CLEAR    = 6'b000010,
      ST_UPD_LEAF = 6'b000100,
      ST_UPD_UP   = 6'b001000,
      ST_QRY_WALK = 6'b010000,
      ST_QRY_DONE = 6'b100000
   } state_type;

endpackage

@@ rtl/core/segtree_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module segtree_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

@@ rtl/core/segment_tree_range_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum
// Point updates and inclusive range sums over signed 32-bit elements, kept as
// a bottom-up segment tree of 42-bit partial sums in one RAM.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   mode, elem_index, new_value,
//                                            range_low, range_high
//  rsp      out        rsp_valid/rsp_stall   range_sum
//  csr      in         csr_wr_en             element_count
//
// An update writes the leaf and then climbs the tree to the root; at each level
// it reads the sibling sum and writes the parent sum.
// A query walks the tree bottom-up with two node reads per level.
// After reset and after every element_count write the tree is cleared, one
// entry per cycle, 2 * leaves entries (2048 by default); requests stall then.
// A finished sum waits in the output register; updates proceed meanwhile.
// ----------------------------------------------------------------------------
module segment_tree_range_sum #(
   parameter int MAX_ELEMENTS = segtree_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic [segtree_pkg::INDEX_W-1:0]        req_elem_index,
   input  logic signed [segtree_pkg::VALUE_W-1:0] req_new_value,
   input  logic [segtree_pkg::INDEX_W-1:0]        req_range_low,
   input  logic [segtree_pkg::INDEX_W-1:0]        req_range_high,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [segtree_pkg::SUM_W-1:0]   rsp_range_sum,
   input  logic                                   csr_wr_en,
   input  logic [segtree_pkg::COUNT_W-1:0]        csr_wr_data
);

   import segtree_pkg::*;

   localparam int LEAF_W     = $clog2(MAX_ELEMENTS);
   localparam int LEAVES     = 1 << LEAF_W;
   localparam int NODE_W     = LEAF_W + 1;
   localparam int TREE_DEPTH = 2 * LEAVES;
   localparam int WALK_W     = NODE_W + 1;
   localparam int COUNT_INIT = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [SUM_W-1:0]   cur_ff, cur_in;
   logic [WALK_W-1:0]  lo_ff, lo_in;
   logic [WALK_W-1:0]  hi_ff, hi_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic               pend_a_ff, pend_a_in;
   logic               pend_b_ff, pend_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic               wr_en;
   logic [NODE_W-1:0]  wr_addr;
   logic [SUM_W-1:0]   wr_data;
   logic [NODE_W-1:0]  rd_addr_a, rd_addr_b;
   logic [SUM_W-1:0]   rd_data_a, rd_data_b;

   logic               req_accept;
   logic [COUNT_W-1:0] last_index;
   logic [COUNT_W-1:0] high_clip;
   logic               range_empty;
   logic [COUNT_W-1:0] count_clamped;
   logic [NODE_W-1:0]  parent;
   logic [SUM_W-1:0]   level_sum;
   logic [WALK_W-1:0]  hi_minus_one;

   segtree_ram #(
      .WIDTH(SUM_W),
      .DEPTH(TREE_DEPTH)
   ) u_tree_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   assign last_index   = count_ff - COUNT_W'(1);
   assign high_clip    = ({1'b0, req_range_high} > last_index) ? last_index
                                                               : {1'b0, req_range_high};
   assign range_empty  = ({1'b0, req_range_low} > high_clip);
   assign parent       = node_ff >> 1;
   assign level_sum    = cur_ff + rd_data_a;
   assign hi_minus_one = hi_ff - WALK_W'(1);

   always_comb begin
      if (csr_wr_data == '0) begin
         count_clamped = COUNT_W'(1);
      end else if (int'(csr_wr_data) > MAX_ELEMENTS) begin
         count_clamped = COUNT_W'(MAX_ELEMENTS);
      end else begin
         count_clamped = csr_wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pend_a_in    = 1'b0;
      pend_b_in    = 1'b0;
      acc_in       = acc_ff + (pend_a_ff ? rd_data_a : '0) + (pend_b_ff ? rd_data_b : '0);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_QUERY) begin
                  lo_in    = WALK_W'(LEAVES) + WALK_W'(req_range_low);
                  hi_in    = range_empty ? lo_in
                                         : WALK_W'(LEAVES) + WALK_W'(high_clip) + WALK_W'(1);
                  acc_in   = '0;
                  state_in = ST_QRY_WALK;
               end else if ({1'b0, req_elem_index} < count_ff) begin
                  node_in  = NODE_W'(LEAVES) + NODE_W'(req_elem_index);
                  cur_in   = SUM_W'(req_new_value);
                  state_in = ST_UPD_LEAF;
               end
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + NODE_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPD_LEAF: begin
            wr_en     = 1'b1;
            wr_addr   = node_ff;
            wr_data   = cur_ff;
            rd_addr_a = node_ff ^ NODE_W'(1);
            state_in  = ST_UPD_UP;
         end
         ST_UPD_UP: begin
            wr_en     = 1'b1;
            wr_addr   = parent;
            wr_data   = level_sum;
            rd_addr_a = parent ^ NODE_W'(1);
            node_in   = parent;
            cur_in    = level_sum;
            if (parent == NODE_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY_WALK: begin
            if (lo_ff < hi_ff) begin
               rd_addr_a = lo_ff[NODE_W-1:0];
               rd_addr_b = hi_minus_one[NODE_W-1:0];
               pend_a_in = lo_ff[0];
               pend_b_in = hi_ff[0];
               lo_in     = (lo_ff + WALK_W'(lo_ff[0])) >> 1;
               hi_in     = hi_ff >> 1;
            end else begin
               state_in = ST_QRY_DONE;
            end
         end
         ST_QRY_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         count_in = count_clamped;
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= COUNT_W'(COUNT_INIT);
         clr_ff       <= '0;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         pend_a_ff    <= pend_a_in;
         pend_b_ff    <= pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   // A new sum appears only when a query walk has finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QRY_DONE))
      else $error("response raised outside query completion");

   // An update aimed past the element count leaves the tree untouched.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == MODE_UPDATE && !csr_wr_en &&
       {1'b0, req_elem_index} >= count_ff) |=> (state_ff == ST_IDLE && !wr_en))
      else $error("out-of-range update reached the tree");

   // The query window never leaves the node space of the tree.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY_WALK) |-> (hi_ff <= WALK_W'(TREE_DEPTH) && lo_ff != '0))
      else $error("query window outside the tree");

   // A result held under stall is not overwritten by a later query.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_sum_ff)))
      else $error("pending response lost");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum testbench
// Drives point updates and range sum queries through the request channel,
// keeps a flat copy of the element array to predict each sum the directed
// table lacks, and compares each returned sum in order. After the table,
// random traffic runs over several element counts and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
   import segtree_pkg::*;

   localparam int MAX_ELEMENTS    = DEFAULT_MAX_ELEMENTS;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 32;
   localparam int STALL_LIMIT     = 20000;
   localparam int ITEMS_PER_PHASE = 136;
   localparam int NUM_PHASES      = 9;
   localparam int NUM_DIRECTED    = 27;

   typedef enum logic {ROW_REQUEST, ROW_COUNT} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic                       mode;
      logic [INDEX_W-1:0]         index;
      logic signed [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]         low;
      logic [INDEX_W-1:0]         high;
      logic [COUNT_W-1:0]         count;
      bit                         typed;
      logic signed [SUM_W-1:0]    sum;
   } directed_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_mode = MODE_UPDATE;
   logic [INDEX_W-1:0]         req_elem_index = '0;
   logic signed [VALUE_W-1:0]  req_new_value = '0;
   logic [INDEX_W-1:0]         req_range_low = '0;
   logic [INDEX_W-1:0]         req_range_high = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]    rsp_range_sum;
   logic                       csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]         csr_wr_data = '0;

   logic signed [SUM_W-1:0]    element_values [MAX_ELEMENTS];
   int                         element_count = MAX_ELEMENTS;
   logic signed [SUM_W-1:0]    sums_due [$];
   logic signed [SUM_W-1:0]    oldest_sum;
   int                         error_count = 0;
   int                         quiet_cycles = 0;
   int                         sender_idle_pct = 20;
   int                         receiver_idle_pct = 87;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd1023, 11'd0, 1'b1,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd0,    32'sh7FFF_FFFF,  10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd1023, 32'sh8000_0000,  10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd512,  32'shFFFF_FFFF,  10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd1,    32'sd1,          10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd1023, 11'd0, 1'b1,
        -42'sd1},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd0,    11'd0, 1'b1,
        42'sd2147483647},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd1023, 10'd1023, 11'd0, 1'b1,
        -42'sd2147483648},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd5,    10'd3,    11'd0, 1'b1,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd1023, 10'd0,    11'd0, 1'b1,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd1,    32'sh5555_5555,  10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd2,    32'shAAAA_AAAA,  10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd2,    11'd0, 1'b0,
        42'sd0},
      '{ROW_COUNT,   MODE_UPDATE, 10'd0,    32'sd0,          10'd0,    10'd0,    11'd10, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd1023, 11'd0, 1'b1,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd10,   32'sd123,        10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd9,    -32'sd5,         10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd0,    32'sh2AAA_AAAA,  10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd1023, 11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd9,    10'd1023, 11'd0, 1'b1,
        -42'sd5},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd10,   10'd20,   11'd0, 1'b1,
        42'sd0},
      '{ROW_COUNT,   MODE_UPDATE, 10'd0,    32'sd0,          10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd0,    32'sd42,         10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_UPDATE, 10'd1,    32'sd7,          10'd0,    10'd0,    11'd0, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd1023, 11'd0, 1'b1,
        42'sd42},
      '{ROW_COUNT,   MODE_UPDATE, 10'd0,    32'sd0,          10'd0,    10'd0,    11'd2047, 1'b0,
        42'sd0},
      '{ROW_REQUEST, MODE_QUERY,  10'd0,    32'sd0,          10'd0,    10'd1023, 11'd0, 1'b1,
        42'sd0}
   };

   segment_tree_range_sum dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_elem_index (req_elem_index),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_range_sum  (rsp_range_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [SUM_W-1:0] range_total(int low, int high);
      logic signed [SUM_W-1:0] total;
      int                      top;
      total = '0;
      top = (high > element_count - 1) ? element_count - 1 : high;
      for (int i = low; i <= top; i++) begin
         total += element_values[i];
      end
      return total;
   endfunction

   task automatic write_count(input logic [COUNT_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (data == 0) begin
         element_count = 1;
      end else if (data > MAX_ELEMENTS) begin
         element_count = MAX_ELEMENTS;
      end else begin
         element_count = int'(data);
      end
      foreach (element_values[i]) begin
         element_values[i] = '0;
      end
   endtask

   task automatic send_request(input logic mode, input logic [INDEX_W-1:0] index,
                               input logic signed [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] low, input logic [INDEX_W-1:0] high,
                               input bit typed, input logic signed [SUM_W-1:0] typed_sum);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode = mode;
      req_elem_index = index;
      req_new_value = value;
      req_range_low = low;
      req_range_high = high;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      if (mode == MODE_UPDATE) begin
         if (index < element_count) begin
            element_values[index] = value;
         end
      end else begin
         sums_due.push_back(typed ? typed_sum : range_total(int'(low), int'(high)));
      end
      @(negedge clock);
   endtask

   task automatic wait_for_sums();
      req_valid = 1'b0;
      while (sums_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic settle();
      wait_for_sums();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               $error("range_sum: no query pending, got %0d", rsp_range_sum);
               error_count++;
            end else begin
               oldest_sum = sums_due.pop_front();
               if (rsp_range_sum !== oldest_sum) begin
                  $error("range_sum: expected %0d, actual %0d", oldest_sum, rsp_range_sum);
                  error_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [COUNT_W-1:0]        phase_counts [NUM_PHASES];
      logic                      mode;
      logic [INDEX_W-1:0]        index;
      logic [INDEX_W-1:0]        low;
      logic [INDEX_W-1:0]        high;
      logic [INDEX_W-1:0]        swap;
      logic signed [VALUE_W-1:0] value;
      int                        top;
      int                        done;
      bit                        paused;

      phase_counts = '{11'd2, 11'd0, 11'd1000, 11'd1, 11'd2047, 11'd13, 11'd1024, 11'd3, 11'd0};
      phase_counts[NUM_PHASES-1] = COUNT_W'($urandom_range(2047));
      foreach (element_values[i]) begin
         element_values[i] = '0;
      end
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_COUNT) begin
            settle();
            write_count(directed_rows[r].count);
         end else begin
            send_request(directed_rows[r].mode, directed_rows[r].index, directed_rows[r].value,
                         directed_rows[r].low, directed_rows[r].high, directed_rows[r].typed,
                         directed_rows[r].sum);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case (phase / 3)
            0: begin
               sender_idle_pct = 20;
               receiver_idle_pct = 87;
            end
            1: begin
               sender_idle_pct = 87;
               receiver_idle_pct = 20;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         write_count(phase_counts[phase]);
         top = element_count - 1;
         done = 0;
         paused = 1'b0;
         while (done < ITEMS_PER_PHASE) begin
            mode = 1'($urandom_range(1));
            index = ($urandom_range(99) < 85) ? INDEX_W'($urandom_range(top))
                                              : INDEX_W'($urandom_range(1023));
            case ($urandom_range(7))
               0: value = 32'sh7FFF_FFFF;
               1: value = 32'sh8000_0000;
               2: value = $urandom_range(20) - 10;
               default: value = $urandom;
            endcase
            if ($urandom_range(9) < 7) begin
               low = INDEX_W'($urandom_range(top));
               high = INDEX_W'($urandom_range(top));
               if (low > high && $urandom_range(4) != 0) begin
                  swap = low;
                  low = high;
                  high = swap;
               end
            end else begin
               low = INDEX_W'($urandom_range(1023));
               high = INDEX_W'($urandom_range(1023));
            end
            send_request(mode, index, value, low, high, 1'b0, '0);
            if (mode == MODE_QUERY || index < element_count) begin
               done++;
            end
            if (!paused && done == ITEMS_PER_PHASE / 2) begin
               wait_for_sums();
               paused = 1'b1;
            end
         end
      end

      settle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
